### hdl/nec_rx_pkg.sv
// nec_rx_pkg: types and constants shared by the nec infrared frame receiver
// used by every module of the receiver except nec_rx_in_reg; depends on nothing

package nec_rx_pkg;

  localparam int unsigned LimW     = 11;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned FrameW   = 32;
  localparam int unsigned BitIdxW  = 5;
  localparam int unsigned ApbAddrW = 5;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned RegIdxW  = 3;

  localparam logic [LimW-1:0] LeaderLowReset  = 11'd1000;
  localparam logic [LimW-1:0] LeaderHighReset = 11'd550;
  localparam logic [LimW-1:0] BitLowReset     = 11'd62;
  localparam logic [LimW-1:0] BitHighReset    = 11'd100;
  localparam logic [LimW-1:0] SampleDlyReset  = 11'd60;

  typedef enum logic [RegIdxW-1:0] {
    REG_LEADER_LOW  = 3'd0,
    REG_LEADER_HIGH = 3'd1,
    REG_BIT_LOW     = 3'd2,
    REG_BIT_HIGH    = 3'd3,
    REG_SAMPLE_DLY  = 3'd4
  } reg_idx_e;

  typedef enum logic [StatusW-1:0] {
    STAT_OK         = 3'd0,
    STAT_LEADER_LOW = 3'd1,
    STAT_LEADER_HI  = 3'd2,
    STAT_BIT_LOW    = 3'd3,
    STAT_BIT_HIGH   = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_LEAD_LOW  = 3'd1,
    PH_LEAD_HIGH = 3'd2,
    PH_BIT_LOW   = 3'd3,
    PH_BIT_WAIT  = 3'd4,
    PH_BIT_HIGH  = 3'd5,
    PH_TRAIL     = 3'd6
  } phase_e;

  typedef struct packed {
    logic [LimW-1:0] leader_low_limit;
    logic [LimW-1:0] leader_high_limit;
    logic [LimW-1:0] bit_low_limit;
    logic [LimW-1:0] bit_high_limit;
    logic [LimW-1:0] sample_delay_ticks;
  } cfg_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  byte_first;
    logic [7:0]  byte_second;
    logic [7:0]  byte_third;
    logic [7:0]  byte_fourth;
  } result_t;

endpackage

### hdl/nec_rx_cfg.sv
// nec_rx_cfg: apb register file holding the five timing limits
// depends on nec_rx_pkg

module nec_rx_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [nec_rx_pkg::ApbAddrW-1:0]   paddr,
  input  logic [nec_rx_pkg::ApbDataW-1:0]   pwdata,
  output logic [nec_rx_pkg::ApbDataW-1:0]   prdata,
  output logic                              pready,
  output nec_rx_pkg::cfg_t                  cfg_o
);

  nec_rx_pkg::cfg_t                    cfg_q, cfg_d;
  logic [nec_rx_pkg::RegIdxW-1:0]      idx;
  logic [nec_rx_pkg::LimW-1:0]         wval;
  logic [nec_rx_pkg::LimW-1:0]         rval;
  logic                                wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[nec_rx_pkg::ApbAddrW-1:2];
  assign wval   = pwdata[nec_rx_pkg::LimW-1:0];
  assign wr_en  = psel & penable & pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        nec_rx_pkg::REG_LEADER_LOW:  cfg_d.leader_low_limit   = wval;
        nec_rx_pkg::REG_LEADER_HIGH: cfg_d.leader_high_limit  = wval;
        nec_rx_pkg::REG_BIT_LOW:     cfg_d.bit_low_limit      = wval;
        nec_rx_pkg::REG_BIT_HIGH:    cfg_d.bit_high_limit     = wval;
        nec_rx_pkg::REG_SAMPLE_DLY:  cfg_d.sample_delay_ticks = wval;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      nec_rx_pkg::REG_LEADER_LOW:  rval = cfg_q.leader_low_limit;
      nec_rx_pkg::REG_LEADER_HIGH: rval = cfg_q.leader_high_limit;
      nec_rx_pkg::REG_BIT_LOW:     rval = cfg_q.bit_low_limit;
      nec_rx_pkg::REG_BIT_HIGH:    rval = cfg_q.bit_high_limit;
      nec_rx_pkg::REG_SAMPLE_DLY:  rval = cfg_q.sample_delay_ticks;
      default:                     rval = '0;
    endcase
  end

  assign prdata = nec_rx_pkg::ApbDataW'(rval);
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.leader_low_limit   <= nec_rx_pkg::LeaderLowReset;
      cfg_q.leader_high_limit  <= nec_rx_pkg::LeaderHighReset;
      cfg_q.bit_low_limit      <= nec_rx_pkg::BitLowReset;
      cfg_q.bit_high_limit     <= nec_rx_pkg::BitHighReset;
      cfg_q.sample_delay_ticks <= nec_rx_pkg::SampleDlyReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### hdl/nec_rx_in_reg.sv
// nec_rx_in_reg: input register for one pin sample word
// depends on nothing beyond plain logic

module nec_rx_in_reg (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  logic ir_level_i,
  input  logic consume_i,
  output logic valid_o,
  output logic level_o
);

  logic valid_q, valid_d;
  logic level_q;
  logic accept;

  assign in_stall_o = valid_q & ~consume_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    if (accept) begin
      valid_d = 1'b1;
    end else if (consume_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      level_q <= ir_level_i;
    end
  end

  assign valid_o = valid_q;
  assign level_o = level_q;

endmodule

### hdl/nec_rx_fsm.sv
// nec_rx_fsm: frame phase machine, tick counter and bit accumulator
// depends on nec_rx_pkg

module nec_rx_fsm #(
  parameter int unsigned COUNT_WIDTH = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic                level_i,
  input  nec_rx_pkg::cfg_t    cfg_i,
  output logic                emit_o,
  output nec_rx_pkg::result_t result_o
);

  localparam int unsigned LimW = nec_rx_pkg::LimW;
  localparam int unsigned CmpW = (COUNT_WIDTH > LimW) ? COUNT_WIDTH : LimW;
  localparam logic [COUNT_WIDTH-1:0] CountMax = '1;
  localparam logic [COUNT_WIDTH-1:0] CountOne = COUNT_WIDTH'(1);
  localparam logic [nec_rx_pkg::BitIdxW-1:0] LastBit = '1;

  nec_rx_pkg::phase_e                  phase_q, phase_d;
  logic [COUNT_WIDTH-1:0]              tick_q, tick_d, tick_inc;
  logic [nec_rx_pkg::BitIdxW-1:0]      idx_q, idx_d;
  logic [nec_rx_pkg::FrameW-1:0]       bits_q, bits_d, bits_out;
  logic                                prev_q;
  logic                                emit;
  nec_rx_pkg::status_e                 status;

  function automatic logic over(input logic [COUNT_WIDTH-1:0] t,
                                input logic [LimW-1:0] lim);
    return CmpW'(t) > CmpW'(lim);
  endfunction

  function automatic logic reached(input logic [COUNT_WIDTH-1:0] t,
                                   input logic [LimW-1:0] lim);
    return CmpW'(t) >= CmpW'(lim);
  endfunction

  assign tick_inc = (tick_q == CountMax) ? tick_q : tick_q + CountOne;

  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    idx_d   = idx_q;
    bits_d  = bits_q;
    emit    = 1'b0;
    status  = nec_rx_pkg::STAT_OK;
    case (phase_q)
      nec_rx_pkg::PH_IDLE: begin
        if (prev_q && !level_i) begin
          phase_d = nec_rx_pkg::PH_LEAD_LOW;
          tick_d  = CountOne;
          idx_d   = '0;
          bits_d  = '0;
          if (over(CountOne, cfg_i.leader_low_limit)) begin
            emit   = 1'b1;
            status = nec_rx_pkg::STAT_LEADER_LOW;
          end
        end
      end
      nec_rx_pkg::PH_LEAD_LOW: begin
        if (!level_i) begin
          tick_d = tick_inc;
          if (over(tick_inc, cfg_i.leader_low_limit)) begin
            emit   = 1'b1;
            status = nec_rx_pkg::STAT_LEADER_LOW;
          end
        end else begin
          phase_d = nec_rx_pkg::PH_LEAD_HIGH;
          tick_d  = CountOne;
          if (over(CountOne, cfg_i.leader_high_limit)) begin
            emit   = 1'b1;
            status = nec_rx_pkg::STAT_LEADER_HI;
          end
        end
      end
      nec_rx_pkg::PH_LEAD_HIGH: begin
        if (level_i) begin
          tick_d = tick_inc;
          if (over(tick_inc, cfg_i.leader_high_limit)) begin
            emit   = 1'b1;
            status = nec_rx_pkg::STAT_LEADER_HI;
          end
        end else begin
          phase_d = nec_rx_pkg::PH_BIT_LOW;
          tick_d  = CountOne;
          if (over(CountOne, cfg_i.bit_low_limit)) begin
            emit   = 1'b1;
            status = nec_rx_pkg::STAT_BIT_LOW;
          end
        end
      end
      nec_rx_pkg::PH_BIT_LOW: begin
        if (!level_i) begin
          tick_d = tick_inc;
          if (over(tick_inc, cfg_i.bit_low_limit)) begin
            emit   = 1'b1;
            status = nec_rx_pkg::STAT_BIT_LOW;
          end
        end else begin
          phase_d = nec_rx_pkg::PH_BIT_WAIT;
          tick_d  = '0;
        end
      end
      nec_rx_pkg::PH_BIT_WAIT, nec_rx_pkg::PH_BIT_HIGH: begin
        tick_d = tick_inc;
        if (phase_q == nec_rx_pkg::PH_BIT_WAIT && reached(tick_inc, cfg_i.sample_delay_ticks)
            && level_i) begin
          bits_d[idx_q] = 1'b1;
          phase_d       = nec_rx_pkg::PH_BIT_HIGH;
          tick_d        = CountOne;
          if (over(CountOne, cfg_i.bit_high_limit)) begin
            emit   = 1'b1;
            status = nec_rx_pkg::STAT_BIT_HIGH;
          end
        end else if (phase_q == nec_rx_pkg::PH_BIT_HIGH && level_i) begin
          if (over(tick_inc, cfg_i.bit_high_limit)) begin
            emit   = 1'b1;
            status = nec_rx_pkg::STAT_BIT_HIGH;
          end
        end else if (phase_q == nec_rx_pkg::PH_BIT_HIGH
                     || reached(tick_inc, cfg_i.sample_delay_ticks)) begin
          // end of bit: next low pulse or trailing wait
          idx_d = idx_q + 1'b1;
          if (idx_q == LastBit) begin
            phase_d = nec_rx_pkg::PH_TRAIL;
            tick_d  = '0;
          end else begin
            phase_d = nec_rx_pkg::PH_BIT_LOW;
            tick_d  = CountOne;
            if (over(CountOne, cfg_i.bit_low_limit)) begin
              emit   = 1'b1;
              status = nec_rx_pkg::STAT_BIT_LOW;
            end
          end
        end
      end
      nec_rx_pkg::PH_TRAIL: begin
        tick_d = tick_inc;
        if (reached(tick_inc, cfg_i.sample_delay_ticks)) begin
          emit   = 1'b1;
          status = nec_rx_pkg::STAT_OK;
        end
      end
      default: begin
        phase_d = nec_rx_pkg::PH_IDLE;
        tick_d  = '0;
      end
    endcase
    if (emit) begin
      phase_d = nec_rx_pkg::PH_IDLE;
      tick_d  = '0;
      idx_d   = '0;
      bits_d  = '0;
    end
  end

  assign bits_out = (status == nec_rx_pkg::STAT_OK) ? bits_q : '0;

  assign emit_o               = emit;
  assign result_o.status      = status;
  assign result_o.byte_first  = bits_out[7:0];
  assign result_o.byte_second = bits_out[15:8];
  assign result_o.byte_third  = bits_out[23:16];
  assign result_o.byte_fourth = bits_out[31:24];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= nec_rx_pkg::PH_IDLE;
      tick_q  <= '0;
      idx_q   <= '0;
      bits_q  <= '0;
      prev_q  <= 1'b1;
    end else if (step_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      idx_q   <= idx_d;
      bits_q  <= bits_d;
      prev_q  <= level_i;
    end
  end

endmodule

### hdl/nec_rx_out_reg.sv
// nec_rx_out_reg: result register holding one status and byte word
// depends on nec_rx_pkg

module nec_rx_out_reg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  nec_rx_pkg::result_t result_i,
  output logic                free_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output nec_rx_pkg::result_t result_o
);

  logic                valid_q, valid_d;
  nec_rx_pkg::result_t res_q;

  assign free_o = ~valid_q | ~out_stall_i;

  always_comb begin
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = res_q;

endmodule

### hdl/nec_ir_frame_receiver.sv
// nec_ir_frame_receiver: top level of the nec infrared frame receiver
// depends on nec_rx_pkg, nec_rx_cfg, nec_rx_in_reg, nec_rx_fsm, nec_rx_out_reg
//
//   channel | handshake                  | payload
//   --------+----------------------------+---------------------------------------
//   in      | in_valid_i / in_stall_o    | ir_level_i
//   out     | out_valid_o / out_stall_i  | status_o, byte_first_o .. byte_fourth_o
//   cfg     | apb psel/penable/pready    | paddr, pwdata, prdata
//
// one word per cycle sustained unless out_stall_i holds a pending result; a sample is taken
// into the input register, then the phase machine steps on it and, when it ends a frame, loads the result register
// a pending result stalls the input only while out_stall_i holds it
// reset puts the machine in idle with the line taken as high, limits at defaults

module nec_ir_frame_receiver #(
  parameter int unsigned COUNT_WIDTH = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            ir_level_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [nec_rx_pkg::StatusW-1:0]  status_o,
  output logic [7:0]                      byte_first_o,
  output logic [7:0]                      byte_second_o,
  output logic [7:0]                      byte_third_o,
  output logic [7:0]                      byte_fourth_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [nec_rx_pkg::ApbAddrW-1:0] paddr,
  input  logic [nec_rx_pkg::ApbDataW-1:0] pwdata,
  output logic [nec_rx_pkg::ApbDataW-1:0] prdata,
  output logic                            pready
);

  nec_rx_pkg::cfg_t    cfg;
  nec_rx_pkg::result_t fsm_res;
  nec_rx_pkg::result_t out_res;
  logic                smp_valid;
  logic                smp_level;
  logic                out_free;
  logic                consume;
  logic                emit;

  assign consume = smp_valid & out_free;

  nec_rx_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  nec_rx_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .ir_level_i (ir_level_i),
    .consume_i  (consume),
    .valid_o    (smp_valid),
    .level_o    (smp_level)
  );

  nec_rx_fsm #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_fsm (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (consume),
    .level_i  (smp_level),
    .cfg_i    (cfg),
    .emit_o   (emit),
    .result_o (fsm_res)
  );

  nec_rx_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (consume & emit),
    .result_i    (fsm_res),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_res)
  );

  assign status_o      = out_res.status;
  assign byte_first_o  = out_res.byte_first;
  assign byte_second_o = out_res.byte_second;
  assign byte_third_o  = out_res.byte_third;
  assign byte_fourth_o = out_res.byte_fourth;

endmodule

### tb/sv/tb.sv
// tb: self-checking testbench for nec_ir_frame_receiver, driven through its sample,
// result and apb ports with its own model of the frame decoder
// depends on nec_rx_pkg and the receiver rtl

module tb;
  import nec_rx_pkg::*;

  localparam int unsigned CountW     = 12;
  localparam int unsigned QuietLimit = 1000;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  logic                ir_level_i  = 1'b1;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [StatusW-1:0]  status_o;
  logic [7:0]          byte_first_o;
  logic [7:0]          byte_second_o;
  logic [7:0]          byte_third_o;
  logic [7:0]          byte_fourth_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [ApbAddrW-1:0] paddr       = '0;
  logic [ApbDataW-1:0] pwdata      = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  nec_ir_frame_receiver #(.COUNT_WIDTH(CountW)) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .ir_level_i    (ir_level_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .byte_first_o  (byte_first_o),
    .byte_second_o (byte_second_o),
    .byte_third_o  (byte_third_o),
    .byte_fourth_o (byte_fourth_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // decoder model state
  cfg_t              rx_cfg = '{LeaderLowReset, LeaderHighReset, BitLowReset, BitHighReset,
                                SampleDlyReset};
  phase_e            rx_phase      = PH_IDLE;
  logic [CountW-1:0] rx_ticks      = '0;
  logic [5:0]        rx_bit        = '0;
  logic [FrameW-1:0] rx_frame      = '0;
  logic              rx_prev_level = 1'b1;

  result_t     frames_due[$];
  result_t     want;
  int unsigned mismatches      = 0;
  int unsigned samples_taken   = 0;
  int unsigned results_checked = 0;
  int unsigned quiet_cycles    = 0;
  int unsigned send_idle_pct   = 0;
  int unsigned stall_pct       = 0;
  int unsigned run_cap         = 2048;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < stall_pct);
  end

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] exp_val);
    $display("mismatch %s: got %0h, expected %0h", what, got, exp_val);
    mismatches++;
  endtask

  function automatic void close_frame(input status_e st);
    result_t r;
    logic [FrameW-1:0] b;
    b = (st == STAT_OK) ? rx_frame : '0;
    r.status = st;
    {r.byte_fourth, r.byte_third, r.byte_second, r.byte_first} = b;
    frames_due.push_back(r);
    rx_phase = PH_IDLE;
    rx_ticks = '0;
    rx_bit   = '0;
    rx_frame = '0;
  endfunction

  function automatic void bump_ticks();
    if (rx_ticks != '1) rx_ticks = rx_ticks + 1'b1;
  endfunction

  function automatic void advance_bit();
    rx_bit = rx_bit + 1'b1;
    if (rx_bit >= FrameW) begin
      rx_phase = PH_TRAIL;
      rx_ticks = '0;
    end else begin
      rx_phase = PH_BIT_LOW;
      rx_ticks = 1;
      if (rx_ticks > rx_cfg.bit_low_limit) close_frame(STAT_BIT_LOW);
    end
  endfunction

  function automatic void decode_sample(input logic lvl);
    logic was;
    was = rx_prev_level;
    rx_prev_level = lvl;
    case (rx_phase)
      PH_IDLE: begin
        if (was && !lvl) begin
          rx_phase = PH_LEAD_LOW;
          rx_ticks = 1;
          rx_bit   = '0;
          rx_frame = '0;
          if (rx_ticks > rx_cfg.leader_low_limit) close_frame(STAT_LEADER_LOW);
        end
      end
      PH_LEAD_LOW: begin
        if (!lvl) begin
          bump_ticks();
          if (rx_ticks > rx_cfg.leader_low_limit) close_frame(STAT_LEADER_LOW);
        end else begin
          rx_phase = PH_LEAD_HIGH;
          rx_ticks = 1;
          if (rx_ticks > rx_cfg.leader_high_limit) close_frame(STAT_LEADER_HI);
        end
      end
      PH_LEAD_HIGH: begin
        if (lvl) begin
          bump_ticks();
          if (rx_ticks > rx_cfg.leader_high_limit) close_frame(STAT_LEADER_HI);
        end else begin
          rx_phase = PH_BIT_LOW;
          rx_ticks = 1;
          if (rx_ticks > rx_cfg.bit_low_limit) close_frame(STAT_BIT_LOW);
        end
      end
      PH_BIT_LOW: begin
        if (!lvl) begin
          bump_ticks();
          if (rx_ticks > rx_cfg.bit_low_limit) close_frame(STAT_BIT_LOW);
        end else begin
          rx_phase = PH_BIT_WAIT;
          rx_ticks = '0;
        end
      end
      PH_BIT_WAIT: begin
        bump_ticks();
        if (rx_ticks >= rx_cfg.sample_delay_ticks) begin
          if (lvl) begin
            rx_frame[rx_bit[4:0]] = 1'b1;
            rx_phase = PH_BIT_HIGH;
            rx_ticks = 1;
            if (rx_ticks > rx_cfg.bit_high_limit) close_frame(STAT_BIT_HIGH);
          end else begin
            advance_bit();
          end
        end
      end
      PH_BIT_HIGH: begin
        if (lvl) begin
          bump_ticks();
          if (rx_ticks > rx_cfg.bit_high_limit) close_frame(STAT_BIT_HIGH);
        end else begin
          advance_bit();
        end
      end
      PH_TRAIL: begin
        bump_ticks();
        if (rx_ticks >= rx_cfg.sample_delay_ticks) close_frame(STAT_OK);
      end
      default: begin
        rx_phase = PH_IDLE;
        rx_ticks = '0;
      end
    endcase
  endfunction

  // values are stable from the falling edge up to the next rising edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        decode_sample(ir_level_i);
        samples_taken++;
      end
      if (out_valid_o && !out_stall_i) begin
        results_checked++;
        if (frames_due.size() == 0) begin
          flag_mismatch("result with nothing expected, status", status_o, '0);
        end else begin
          want = frames_due.pop_front();
          if (status_o !== want.status) flag_mismatch("status", status_o, want.status);
          if (byte_first_o !== want.byte_first)
            flag_mismatch("byte_first", byte_first_o, want.byte_first);
          if (byte_second_o !== want.byte_second)
            flag_mismatch("byte_second", byte_second_o, want.byte_second);
          if (byte_third_o !== want.byte_third)
            flag_mismatch("byte_third", byte_third_o, want.byte_third);
          if (byte_fourth_o !== want.byte_fourth)
            flag_mismatch("byte_fourth", byte_fourth_o, want.byte_fourth);
        end
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("timeout after %0d quiet cycles", quiet_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic apb_access(input bit wr, input reg_idx_e idx,
                            input logic [ApbDataW-1:0] wdata,
                            output logic [ApbDataW-1:0] rdata);
    bit rdy;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      rdy   = pready;
      rdata = prdata;
      @(posedge clk_i);
    end while (!rdy);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic readback(input reg_idx_e idx);
    logic [ApbDataW-1:0] got;
    logic [LimW-1:0]     exp_val;
    apb_access(1'b0, idx, '0, got);
    case (idx)
      REG_LEADER_LOW:  exp_val = rx_cfg.leader_low_limit;
      REG_LEADER_HIGH: exp_val = rx_cfg.leader_high_limit;
      REG_BIT_LOW:     exp_val = rx_cfg.bit_low_limit;
      REG_BIT_HIGH:    exp_val = rx_cfg.bit_high_limit;
      default:         exp_val = rx_cfg.sample_delay_ticks;
    endcase
    if (got !== ApbDataW'(exp_val)) flag_mismatch("register readback", got, exp_val);
  endtask

  task automatic program_reg(input reg_idx_e idx, input logic [LimW-1:0] value);
    logic [ApbDataW-1:0] ignored;
    apb_access(1'b1, idx, ApbDataW'(value), ignored);
    case (idx)
      REG_LEADER_LOW:  rx_cfg.leader_low_limit   = value;
      REG_LEADER_HIGH: rx_cfg.leader_high_limit  = value;
      REG_BIT_LOW:     rx_cfg.bit_low_limit      = value;
      REG_BIT_HIGH:    rx_cfg.bit_high_limit     = value;
      default:         rx_cfg.sample_delay_ticks = value;
    endcase
    readback(idx);
  endtask

  task automatic send_sample(input logic lvl);
    int unsigned gap;
    bit          stalled;
    gap = 0;
    while (gap < 20 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    ir_level_i <= lvl;
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
  endtask

  task automatic send_run(input logic lvl, input int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++) send_sample(lvl);
  endtask

  // msb first
  task automatic send_bits(input logic [31:0] pattern, input int unsigned n);
    int i;
    for (i = n - 1; i >= 0; i--) send_sample(pattern[i]);
  endtask

  function automatic int unsigned run_len(input logic [LimW-1:0] limit, input bit too_long);
    if (too_long) return limit + $urandom_range(1, 2);
    return $urandom_range(1, (limit < run_cap) ? limit : run_cap);
  endfunction

  // fault_run picks the phase run that is stretched past its limit, -1 for none:
  // 0 leader low, 1 leader high, then low and high of each bit in turn
  task automatic send_frame(input logic [FrameW-1:0] data, input int fault_run);
    int unsigned dly, n, t;
    int          k;
    bit          low_sent;
    dly = (rx_cfg.sample_delay_ticks == 0) ? 1 : rx_cfg.sample_delay_ticks;
    send_sample(1'b1);
    send_run(1'b0, run_len(rx_cfg.leader_low_limit, fault_run == 0));
    if (fault_run == 0) return;
    send_run(1'b1, run_len(rx_cfg.leader_high_limit, fault_run == 1));
    if (fault_run == 1) return;
    low_sent = 1'b0;
    for (k = 0; k < FrameW; k++) begin
      n = run_len(rx_cfg.bit_low_limit, fault_run == 2 + 2 * k);
      send_run(1'b0, n - low_sent);
      if (fault_run == 2 + 2 * k) return;
      send_sample(1'b1);
      for (t = 1; t < dly; t++) send_sample($urandom_range(0, 1));
      if (data[k] || fault_run == 3 + 2 * k) begin
        send_run(1'b1, run_len(rx_cfg.bit_high_limit, fault_run == 3 + 2 * k));
        if (fault_run == 3 + 2 * k) return;
        low_sent = 1'b0;
      end else begin
        send_sample(1'b0);
        low_sent = 1'b1;
      end
    end
    if (!low_sent) send_sample(1'b0);
    for (t = 0; t < dly; t++) send_sample($urandom_range(0, 1));
  endtask

  task automatic run_to_idle();
    while (rx_phase != PH_IDLE)
      send_sample((rx_phase == PH_LEAD_LOW || rx_phase == PH_BIT_LOW) ? 1'b0 : 1'b1);
  endtask

  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (frames_due.size() != 0);
  endtask

  task automatic set_limits(input logic [LimW-1:0] ll, lh, bl, bh, sd);
    run_to_idle();
    hold_until_drained();
    repeat (6) @(posedge clk_i);
    program_reg(REG_LEADER_LOW, ll);
    program_reg(REG_LEADER_HIGH, lh);
    program_reg(REG_BIT_LOW, bl);
    program_reg(REG_BIT_HIGH, bh);
    program_reg(REG_SAMPLE_DLY, sd);
  endtask

  task automatic test_register_access();
    reg_idx_e idx;
    idx = idx.first();
    do begin
      readback(idx);
      idx = idx.next();
    end while (idx != idx.first());
    set_limits('0, '0, '0, '0, '0);
    set_limits('1, '1, '1, '1, '1);
  endtask

  task automatic test_phase_errors();
    set_limits(2, 2, 2, 2, 0);
    send_bits(32'b1000, 4);
    send_bits(32'b10111, 5);
    send_bits(32'b101000, 6);
    send_bits(32'b10101111, 8);
  endtask

  task automatic test_zero_limits();
    set_limits(0, 2, 2, 2, 1);
    send_bits(32'b10, 2);
    set_limits(1, 0, 2, 2, 1);
    send_bits(32'b101, 3);
    set_limits(1, 1, 0, 2, 1);
    send_bits(32'b1010, 4);
    set_limits(1, 1, 1, 0, 1);
    send_bits(32'b101011, 6);
  endtask

  task automatic test_frame_extremes();
    set_limits(3, 3, 2, 2, 0);
    send_frame('1, -1);
    send_frame('0, -1);
    set_limits(3, 3, 2, 2, 2);
    send_frame($urandom, -1);
  endtask

  // largest limits with short runs, a full frame that never trips
  task automatic test_limit_ceiling();
    set_limits('1, '1, '1, '1, 1);
    run_cap = 2;
    send_frame($urandom, -1);
    run_cap = 2048;
  endtask

  task automatic test_random_traffic();
    int unsigned m, s, pick, seg_samples, seg_results;
    for (m = 0; m < 4; m++) begin
      for (s = 0; s < 2; s++) begin
        if (s == 0)
          set_limits($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 4),
                     $urandom_range(1, 4), $urandom_range(0, 4));
        else
          set_limits($urandom_range(1, 16), $urandom_range(1, 16), $urandom_range(1, 8),
                     $urandom_range(1, 8), $urandom_range(0, 8));
        case (m)
          0: begin
            send_idle_pct = 0;
            stall_pct     = 0;
          end
          1: begin
            send_idle_pct = 66;
            stall_pct     = 0;
          end
          2: begin
            send_idle_pct = 0;
            stall_pct     = 66;
          end
          default: begin
            send_idle_pct = 32;
            stall_pct     = 32;
          end
        endcase
        seg_samples = samples_taken + 60;
        seg_results = results_checked + 1;
        while (samples_taken < seg_samples || results_checked < seg_results) begin
          pick = $urandom_range(0, 99);
          if (pick < 3) hold_until_drained();
          if (pick < 55) begin
            run_to_idle();
            send_frame($urandom, -1);
          end else if (pick < 85) begin
            run_to_idle();
            send_frame($urandom, $urandom_range(0, 65));
          end else begin
            repeat ($urandom_range(1, 12)) send_sample($urandom_range(0, 1));
          end
        end
      end
    end
    send_idle_pct = 0;
    stall_pct     = 0;
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_register_access();
    test_phase_errors();
    test_zero_limits();
    test_frame_extremes();
    test_limit_ceiling();
    test_random_traffic();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (frames_due.size() != 0);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
